### hdl/bed_pkg.sv
// Shared types and constants for the backslash escape decoder.
package bed_pkg;

  // Decoder mode, kept by the front end
  typedef enum logic [2:0] {
    MODE_NORMAL    = 3'd0,
    MODE_ESCAPE    = 3'd1,
    MODE_OCTAL     = 3'd2,
    MODE_HEX_FIRST = 3'd3,
    MODE_HEX       = 3'd4
  } mode_t;

  // Error codes carried on the result tuser
  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_NULL_ESCAPE = 2'd1,
    ERR_INVALID     = 2'd2
  } err_t;

  // Character and value constants
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] ESC_CODE  = 8'h1B;
  localparam logic [7:0] SAT_MAX   = 8'hFF;

  // Octal run length and the width of the digit count
  localparam int OCT_DIGITS = 4;
  localparam int LEFT_W     = 2;
  localparam logic [LEFT_W-1:0] OCT_LEFT_INIT = LEFT_W'(OCT_DIGITS - 1);

  // Digit accumulator width (four octal digits)
  localparam int VAL_W = 12;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One result item
  typedef struct packed {
    logic [7:0] data;
    err_t       err;
    logic       last;
  } result_t;

  // One queue entry: the results caused by one input item
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  // Front end to queue write side
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // Queue read side to back end
  typedef struct packed {
    logic   avail;
    entry_t entry;
  } qhead_t;

endpackage

### hdl/bed_front.sv
// Front end: accepts input bytes, tracks the escape mode and builds result entries.
module bed_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // [7:0] in_byte
  input  logic           in_tlast,   // end_of_string
  input  logic           q_full,
  output bed_pkg::push_t push
);
  import bed_pkg::*;

  mode_t              mode_r, mode_nxt;
  logic [VAL_W-1:0]   value_r, value_nxt;
  logic [LEFT_W-1:0]  left_r, left_nxt;
  logic               discard_r, discard_nxt;

  logic               accept;
  logic               consumed, failed, eos;
  err_t               fail_code;
  logic               a_v, b_v, t_v;
  result_t            a_res, b_res, t_res;
  result_t            r0, r1;
  logic               two;
  logic [VAL_W-1:0]   oct_val;
  logic [LEFT_W-1:0]  oct_left;
  logic [8:0]         esc;
  logic [4:0]         hex;

  // Simple escape lookup: {hit, value}
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h22:   r = {1'b1, 8'h22};   // double quote
      8'h27:   r = {1'b1, 8'h27};   // apostrophe
      8'h5C:   r = {1'b1, 8'h5C};   // backslash
      8'h61:   r = {1'b1, 8'h07};   // a
      8'h62:   r = {1'b1, 8'h08};   // b
      8'h45:   r = {1'b1, ESC_CODE}; // E
      8'h65:   r = {1'b1, ESC_CODE}; // e
      8'h66:   r = {1'b1, 8'h0C};   // f
      8'h6E:   r = {1'b1, 8'h0A};   // n
      8'h72:   r = {1'b1, 8'h0D};   // r
      8'h74:   r = {1'b1, 8'h09};   // t
      8'h76:   r = {1'b1, 8'h0B};   // v
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  // Hex digit: {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  function automatic logic [7:0] sat_byte(input logic [VAL_W-1:0] v);
    return (|v[VAL_W-1:8]) ? SAT_MAX : v[7:0];
  endfunction

  function automatic result_t mk_res(input logic [7:0] d, input err_t e);
    result_t r;
    r.data = d;
    r.err  = e;
    r.last = 1'b0;
    return r;
  endfunction

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign eos       = in_tlast;
  assign esc       = simple_escape(in_tdata);
  assign hex       = hex_val(in_tdata);
  assign oct_val   = {value_r[VAL_W-4:0], in_tdata[2:0]};
  assign oct_left  = left_r - LEFT_W'(1);

  // Mode state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      value_r   <= '0;
      left_r    <= '0;
      discard_r <= 1'b0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      value_r   <= value_nxt;
      left_r    <= left_nxt;
      discard_r <= discard_nxt;
    end
  end

  // Next mode and results for the byte on the input
  always_comb begin
    mode_nxt    = mode_r;
    value_nxt   = value_r;
    left_nxt    = left_r;
    discard_nxt = discard_r;
    consumed    = 1'b0;
    failed      = 1'b0;
    fail_code   = ERR_NONE;
    a_v         = 1'b0;
    b_v         = 1'b0;
    t_v         = 1'b0;
    a_res       = mk_res(8'd0, ERR_NONE);
    b_res       = mk_res(in_tdata, ERR_NONE);
    t_res       = mk_res(8'd0, ERR_NONE);

    if (discard_r) begin
      // drop bytes up to the end of the string
      if (eos) begin
        discard_nxt = 1'b0;
        mode_nxt    = MODE_NORMAL;
        value_nxt   = '0;
        left_nxt    = '0;
      end
    end else begin
      case (mode_r)
        MODE_OCTAL: begin
          if (is_oct(in_tdata)) begin
            consumed = 1'b1;
            if (oct_left == '0) begin
              a_v       = 1'b1;
              a_res     = mk_res(sat_byte(oct_val), ERR_NONE);
              mode_nxt  = MODE_NORMAL;
              value_nxt = '0;
              left_nxt  = '0;
            end else begin
              value_nxt = oct_val;
              left_nxt  = oct_left;
            end
          end else begin
            a_v       = 1'b1;
            a_res     = mk_res(sat_byte(value_r), ERR_NONE);
            mode_nxt  = MODE_NORMAL;
            value_nxt = '0;
            left_nxt  = '0;
          end
        end
        MODE_HEX: begin
          a_v = 1'b1;
          if (hex[4]) begin
            consumed = 1'b1;
            a_res    = mk_res({value_r[3:0], hex[3:0]}, ERR_NONE);
          end else begin
            a_res    = mk_res(value_r[7:0], ERR_NONE);
          end
          mode_nxt  = MODE_NORMAL;
          value_nxt = '0;
          left_nxt  = '0;
        end
        MODE_HEX_FIRST: begin
          consumed = 1'b1;
          if (hex[4]) begin
            value_nxt = {{(VAL_W-4){1'b0}}, hex[3:0]};
            left_nxt  = '0;
            mode_nxt  = MODE_HEX;
          end else begin
            failed    = 1'b1;
            fail_code = ERR_INVALID;
          end
        end
        MODE_ESCAPE: begin
          consumed = 1'b1;
          if (esc[8]) begin
            a_v       = 1'b1;
            a_res     = mk_res(esc[7:0], ERR_NONE);
            mode_nxt  = MODE_NORMAL;
            value_nxt = '0;
            left_nxt  = '0;
          end else if (is_oct(in_tdata)) begin
            value_nxt = {{(VAL_W-3){1'b0}}, in_tdata[2:0]};
            left_nxt  = OCT_LEFT_INIT;
            mode_nxt  = MODE_OCTAL;
          end else if (in_tdata == CH_X) begin
            value_nxt = '0;
            left_nxt  = '0;
            mode_nxt  = MODE_HEX_FIRST;
          end else begin
            failed    = 1'b1;
            fail_code = ERR_INVALID;
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
        end
      endcase

      // plain byte handling, also for a byte that ended a digit run
      if (!consumed && !failed) begin
        if (in_tdata == CH_BSLASH) begin
          mode_nxt = MODE_ESCAPE;
        end else begin
          b_v = 1'b1;
        end
      end

      // end of string: flush an open run or report an open escape
      if (!failed && eos) begin
        case (mode_nxt)
          MODE_OCTAL: begin
            t_v   = 1'b1;
            t_res = mk_res(sat_byte(value_nxt), ERR_NONE);
          end
          MODE_HEX: begin
            t_v   = 1'b1;
            t_res = mk_res(value_nxt[7:0], ERR_NONE);
          end
          MODE_ESCAPE: begin
            failed    = 1'b1;
            fail_code = ERR_NULL_ESCAPE;
          end
          MODE_HEX_FIRST: begin
            failed    = 1'b1;
            fail_code = ERR_INVALID;
          end
          default: begin
            t_v = 1'b0;
          end
        endcase
      end

      if (failed) begin
        t_v         = 1'b1;
        t_res       = mk_res(8'd0, fail_code);
        discard_nxt = !eos;
      end
      if (failed || eos) begin
        mode_nxt  = MODE_NORMAL;
        value_nxt = '0;
        left_nxt  = '0;
      end
    end

    // pack the candidates into at most two slots
    r0  = t_res;
    r1  = t_res;
    two = 1'b0;
    if (a_v) begin
      r0  = a_res;
      r1  = b_v ? b_res : t_res;
      two = b_v || t_v;
    end else if (b_v) begin
      r0  = b_res;
      two = t_v;
    end

    // final flag on the last result of the string
    if (!discard_r && (eos || failed)) begin
      if (two) begin
        r1.last = 1'b1;
      end else begin
        r0.last = 1'b1;
      end
    end

    push.valid     = accept && !discard_r && (a_v || b_v || t_v);
    push.entry.two = two;
    push.entry.r0  = r0;
    push.entry.r1  = r1;
  end

endmodule

### hdl/bed_queue.sv
// Short queue of result entries between the front and back ends.
module bed_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  bed_pkg::push_t  push,
  input  logic            pop,
  output logic            full,
  output bed_pkg::qhead_t head
);
  import bed_pkg::*;

  entry_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head.avail = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.avail;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push.valid && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (!push.valid && do_pop) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

### hdl/bed_back.sv
// Back end: unpacks queue entries into single result items on the output register.
module bed_back (
  input  logic            clk,
  input  logic            rst_n,
  input  bed_pkg::qhead_t head,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [1:0]      out_tuser,  // [1:0] error_code
  output logic            out_tlast   // final_result
);
  import bed_pkg::*;

  logic     out_valid_r;
  result_t  out_res_r, out_res_nxt;
  logic     pend_valid_r, pend_valid_nxt;
  result_t  pend_res_r, pend_res_nxt;
  logic     out_free, load;

  assign out_free = !out_valid_r || out_tready;
  assign pop      = out_free && !pend_valid_r && head.avail;
  assign load     = out_free && (pend_valid_r || head.avail);

  // Choose what goes to the output register next
  always_comb begin
    out_res_nxt    = out_res_r;
    pend_res_nxt   = pend_res_r;
    pend_valid_nxt = pend_valid_r;
    if (out_free) begin
      if (pend_valid_r) begin
        out_res_nxt    = pend_res_r;
        pend_valid_nxt = 1'b0;
      end else if (head.avail) begin
        out_res_nxt    = head.entry.r0;
        pend_res_nxt   = head.entry.r1;
        pend_valid_nxt = head.entry.two;
      end
    end
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= load;
      end
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    pend_res_r <= pend_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.data;
  assign out_tuser  = out_res_r.err;
  assign out_tlast  = out_res_r.last;

endmodule

### hdl/backslash_escape_decoder_core.sv
// Top level of the backslash escape decoder.
//
// Decodes a C-style escaped string arriving one byte per item on the in_
// stream (tdata = raw byte, tlast = final byte of the string) and delivers
// decoded bytes on the out_ stream (tdata = byte, tuser = error code,
// tlast = last result of the string). An error item carries byte zero and
// tlast; the rest of that string is dropped without results.
// The front end updates the escape mode in the cycle an item is accepted and
// writes the item's one or two results as one entry into a four-entry
// queue; an item with no result writes no entry. The back end drains
// entries through an output register, one result per cycle while the
// receiver is ready. Each result is written to the queue at the edge that
// accepts its item, then moves into the output register. Throughput: one
// item per cycle while the receiver is ready and each item yields at most
// one result; the two results of an item take the output register in turn.
// Reset returns the decoder to normal text mode, empties the queue and
// drops out_tvalid. When the receiver stalls, out_ holds its item, the
// queue fills, and in_tready falls once all four entries are occupied.
module backslash_escape_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] error_code
  output logic       out_tlast   // final_result
);
  import bed_pkg::*;

  push_t  push;
  qhead_t head;
  logic   q_full;
  logic   pop;

  bed_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push)
  );

  bed_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  bed_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### hdl/bed_checker.sv
// Port-level checks for the backslash escape decoder, bound to the top level.
module bed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);
  import bed_pkg::*;

  // Reset empties the output stage
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // An error result carries byte zero and closes the string
  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ERR_NONE) |-> (out_tdata == 8'd0) && out_tlast)
    else $error("malformed error result");

  // Only defined error codes appear
  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ERR_NONE) || (out_tuser == ERR_NULL_ESCAPE) ||
                   (out_tuser == ERR_INVALID))
    else $error("undefined error code");

endmodule

bind backslash_escape_decoder_core bed_checker u_bed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### verif/backslash_escape_decoder_core_test.sv
// Self-checking testbench for the backslash escape decoder core.
module backslash_escape_decoder_core_test;
  import bed_pkg::*;

  // One decoded result as seen on the out_ stream
  typedef struct packed {
    logic [7:0] data;
    err_t       err;
    logic       last;
  } decoded_t;

  // One row of directed stimulus; typed rows carry their own results
  typedef struct packed {
    logic [7:0] in_b;
    logic       eos;
    logic       typed;
    logic [1:0] n_exp;
    decoded_t   r0;
    decoded_t   r1;
  } stim_row_t;

  localparam decoded_t NO_RES = '{8'h00, ERR_NONE, 1'b0};
  localparam int RANDOM_ITEMS = 1525;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_LIMIT  = 5000;

  // Directed strings: extremes, a simple escape, octal and hex runs, errors
  localparam stim_row_t DIRECTED [27] = '{
    '{8'h00,     1'b0, 1'b1, 2'd1, '{8'h00, ERR_NONE, 1'b0}, NO_RES},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{"e",       1'b0, 1'b1, 2'd1, '{ESC_CODE, ERR_NONE, 1'b0}, NO_RES},
    // four sevens: run closes on its own and saturates
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{"7",       1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{"7",       1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{"7",       1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{"7",       1'b0, 1'b1, 2'd1, '{SAT_MAX, ERR_NONE, 1'b0}, NO_RES},
    // two hex digits, mixed case
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{CH_X,      1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{"f",       1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{"F",       1'b0, 1'b1, 2'd1, '{SAT_MAX, ERR_NONE, 1'b0}, NO_RES},
    // octal run ended by a non-octal digit: flush, then the byte itself
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{"1",       1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{"8",       1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'hFF,     1'b1, 1'b1, 2'd1, '{8'hFF, ERR_NONE, 1'b1}, NO_RES},
    // hex run cut by the end of the string
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{CH_X,      1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{"A",       1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
    // unknown escape, then the rest of the string is dropped
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{"q",       1'b0, 1'b1, 2'd1, '{8'h00, ERR_INVALID, 1'b1}, NO_RES},
    '{8'hFF,     1'b1, 1'b1, 2'd0, NO_RES, NO_RES},
    // lone backslash as the final byte
    '{CH_BSLASH, 1'b1, 1'b1, 2'd1, '{8'h00, ERR_NULL_ESCAPE, 1'b1}, NO_RES},
    // null byte after a backslash
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{8'h00,     1'b1, 1'b1, 2'd1, '{8'h00, ERR_INVALID, 1'b1}, NO_RES},
    // \x with no digit before the end
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{CH_X,      1'b1, 1'b1, 2'd1, '{8'h00, ERR_INVALID, 1'b1}, NO_RES}
  };

  localparam logic [7:0] SIMPLE_ESCAPES [12] = '{
    8'h22, 8'h27, CH_BSLASH, "a", "b", "e", "E", "f", "n", "r", "t", "v"
  };

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_byte
  logic       in_tlast;   // end_of_string
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic [1:0] out_tuser;  // [1:0] error_code
  logic       out_tlast;  // final_result

  // Decoder model state
  mode_t       dec_mode;
  logic [11:0] run_value;
  logic [2:0]  run_left;
  logic        dropping;

  decoded_t   pending_chars[$];
  decoded_t   step_results[$];
  decoded_t   typed_results[$];
  logic [7:0] text[$];

  int  fail_count      = 0;
  int  results_checked = 0;
  int  error_results   = 0;
  int  items_in        = 0;
  int  useful_items    = 0;
  int  strings_sent    = 0;
  bit  quiet           = 0;
  bit  sender_steady   = 0;
  bit  hold_request    = 0;

  backslash_escape_decoder_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net against a hung handshake
  initial begin
    #5_000_000;
    $display("Run stopped: decoder made no progress");
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------- model

  // {hit, value} for the single-character escapes
  function automatic logic [8:0] simple_escape_value(input logic [7:0] c);
    case (c)
      8'h22, 8'h27, CH_BSLASH: return {1'b1, c};
      "a":      return {1'b1, 8'd7};
      "b":      return {1'b1, 8'd8};
      "e", "E": return {1'b1, ESC_CODE};
      "f":      return {1'b1, 8'd12};
      "n":      return {1'b1, 8'd10};
      "r":      return {1'b1, 8'd13};
      "t":      return {1'b1, 8'd9};
      "v":      return {1'b1, 8'd11};
      default:  return 9'd0;
    endcase
  endfunction

  // Hex digit value, 16 for anything else
  function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return 5'd16;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic logic [7:0] clamp_run(input logic [11:0] v);
    return (v > 12'd255) ? SAT_MAX : v[7:0];
  endfunction

  function automatic void emit(input logic [7:0] d, input err_t e);
    step_results.push_back('{d, e, 1'b0});
  endfunction

  function automatic void restart_run();
    dec_mode  = MODE_NORMAL;
    run_value = '0;
    run_left  = '0;
  endfunction

  // Works out the results of one accepted byte into step_results
  function automatic void decode_byte(input logic [7:0] b, input logic eos);
    logic       taken;
    logic       bad;
    err_t       bad_code;
    logic [8:0] esc;
    logic [4:0] hv;
    taken    = 1'b0;
    bad      = 1'b0;
    bad_code = ERR_NONE;
    step_results.delete();
    if (dropping) begin
      if (eos) begin
        dropping = 1'b0;
        restart_run();
      end
      return;
    end
    case (dec_mode)
      MODE_OCTAL: begin
        if (is_octal(b)) begin
          run_value = {run_value[8:0], b[2:0]};
          run_left  = run_left - 3'd1;
          if (run_left == 3'd0) begin
            emit(clamp_run(run_value), ERR_NONE);
            restart_run();
          end
          taken = 1'b1;
        end else begin
          emit(clamp_run(run_value), ERR_NONE);
          restart_run();
        end
      end
      MODE_HEX: begin
        hv = hex_digit_value(b);
        if (hv < 5'd16) begin
          emit({run_value[3:0], hv[3:0]}, ERR_NONE);
          taken = 1'b1;
        end else begin
          emit(run_value[7:0], ERR_NONE);
        end
        restart_run();
      end
      MODE_HEX_FIRST: begin
        hv = hex_digit_value(b);
        if (hv < 5'd16) begin
          run_value = {8'd0, hv[3:0]};
          run_left  = 3'd1;
          dec_mode  = MODE_HEX;
        end else begin
          bad      = 1'b1;
          bad_code = ERR_INVALID;
        end
        taken = 1'b1;
      end
      MODE_ESCAPE: begin
        esc = simple_escape_value(b);
        if (esc[8]) begin
          emit(esc[7:0], ERR_NONE);
          restart_run();
        end else if (is_octal(b)) begin
          run_value = {9'd0, b[2:0]};
          run_left  = 3'd3;
          dec_mode  = MODE_OCTAL;
        end else if (b == CH_X) begin
          run_value = '0;
          run_left  = 3'd2;
          dec_mode  = MODE_HEX_FIRST;
        end else begin
          bad      = 1'b1;
          bad_code = ERR_INVALID;
        end
        taken = 1'b1;
      end
      default: dec_mode = MODE_NORMAL;
    endcase

    // plain text, or the byte that closed a digit run
    if (!taken && !bad) begin
      if (b == CH_BSLASH) dec_mode = MODE_ESCAPE;
      else emit(b, ERR_NONE);
    end

    // string end inside an escape
    if (!bad && eos) begin
      case (dec_mode)
        MODE_OCTAL: emit(clamp_run(run_value), ERR_NONE);
        MODE_HEX:   emit(run_value[7:0], ERR_NONE);
        MODE_ESCAPE: begin
          bad      = 1'b1;
          bad_code = ERR_NULL_ESCAPE;
        end
        MODE_HEX_FIRST: begin
          bad      = 1'b1;
          bad_code = ERR_INVALID;
        end
        default: ;
      endcase
    end

    if (bad) begin
      emit(8'h00, bad_code);
      step_results[step_results.size()-1].last = 1'b1;
      restart_run();
      dropping = !eos;
    end else if (eos) begin
      restart_run();
      if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------- sender

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one byte and records its expected results once accepted
  task automatic send_item(input logic [7:0] b, input logic eos, input logic typed);
    int   gap;
    logic was_dropping;
    gap = (quiet || sender_steady) ? 0 : idle_length();
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    was_dropping = dropping;
    decode_byte(b, eos);
    if (typed) foreach (typed_results[i]) pending_chars.push_back(typed_results[i]);
    else foreach (step_results[i]) pending_chars.push_back(step_results[i]);
    items_in++;
    if (!was_dropping) useful_items++;
  endtask

  task automatic pause_sender();
    @(negedge clk) in_tvalid <= 1'b0;
  endtask

  // Waits for every outstanding result; leftovers count as failures
  task automatic wait_drained();
    int waited;
    waited = 0;
    while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_chars.size() != 0) begin
      $error("%0d expected results never arrived", pending_chars.size());
      fail_count++;
      pending_chars.delete();
    end
  endtask

  function automatic logic [7:0] octal_char();
    return 8'h30 + 8'($urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - 10);
  endfunction

  // One piece of a string: mostly well-formed, some broken escapes
  task automatic add_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      case ($urandom_range(0, 2))
        0:       text.push_back(octal_char());
        1:       text.push_back(hex_char());
        default: text.push_back(8'($urandom_range(0, 255)));
      endcase
    end else if (r < 55) begin
      text.push_back(CH_BSLASH);
      text.push_back(SIMPLE_ESCAPES[$urandom_range(0, 11)]);
    end else if (r < 75) begin
      text.push_back(CH_BSLASH);
      repeat ($urandom_range(1, 4)) text.push_back(octal_char());
    end else if (r < 90) begin
      text.push_back(CH_BSLASH);
      text.push_back(CH_X);
      repeat ($urandom_range(1, 2)) text.push_back(hex_char());
    end else if (r < 95) begin
      text.push_back(CH_BSLASH);
      text.push_back(8'($urandom_range(0, 255)));
    end else begin
      text.push_back(CH_BSLASH);
      text.push_back(CH_X);
      text.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_string();
    int n;
    text.delete();
    if ($urandom_range(0, 9) == 0) begin
      // raw noise with a fair share of backslashes
      n = $urandom_range(1, 10);
      repeat (n) text.push_back($urandom_range(0, 4) == 0 ? CH_BSLASH : 8'($urandom));
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
      repeat (n) add_token();
      if ($urandom_range(0, 24) == 0) text.push_back(CH_BSLASH);
    end
  endtask

  task automatic send_string();
    foreach (text[i]) send_item(text[i], i == text.size() - 1, 1'b0);
    strings_sent++;
  endtask

  // ---------------------------------------------------------------- receiver

  // Random back-pressure, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (hold_request) begin
        out_tready   <= 1'b0;
        stall_left   = HOLD_CYCLES - 1;
        hold_request = 0;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        out_tready <= 1'b0;
        stall_left = idle_length();
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : check_results
    decoded_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected result: out_byte %0h error_code %0d", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        results_checked++;
        if (want.err != ERR_NONE) error_results++;
        if (out_tdata !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, out_tuser);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("final_result: expected %0b, got %0b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    stim_row_t row;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    dropping  = 1'b0;
    restart_run();
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed strings
    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      typed_results.delete();
      if (row.n_exp >= 2'd1) typed_results.push_back(row.r0);
      if (row.n_exp >= 2'd2) typed_results.push_back(row.r1);
      send_item(row.in_b, row.eos, row.typed);
    end
    pause_sender();
    wait_drained();

    // random strings, with one long output hold-off, a gap-free stretch, a quiet stretch and a mid-run drain
    while (useful_items < $size(DIRECTED) + RANDOM_ITEMS) begin
      if (strings_sent == 40) begin
        hold_request  = 1;
        sender_steady = 1;
      end
      if (strings_sent == 47) sender_steady = 0;
      quiet = (strings_sent >= 100 && strings_sent < 125);
      if (strings_sent == 150) begin
        pause_sender();
        wait_drained();
      end
      build_string();
      send_string();
    end
    quiet = 0;
    pause_sender();
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d strings (%0d bytes, %0d decoded outside dropped tails)",
             strings_sent, items_in, useful_items);
    $display("Checked %0d results, %0d of them error reports", results_checked,
             error_results);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/bed_pkg.sv
hdl/bed_front.sv
hdl/bed_queue.sv
hdl/bed_back.sv
hdl/backslash_escape_decoder_core.sv
hdl/bed_checker.sv
verif/backslash_escape_decoder_core_test.sv
